### sv/great_circle_bearing_distance_defines.svh
// Assertion macros shared by the great-circle bearing and distance RTL.
// Standalone header; the asserting module pulls it in by include.
`ifndef GREAT_CIRCLE_BEARING_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_BEARING_DISTANCE_DEFINES_SVH

// Checks the consequence in the same cycle as the condition.
`define GCBD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks the consequence in the cycle after the condition.
`define GCBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/gcbd_pkg.sv
// Shared constants, angle table and lane types for the great-circle unit.
// No dependencies; every module file refers to it by scoped names.
package gcbd_pkg;

   localparam int ANGLE_ITERATIONS = 16;
   localparam int STEP_W           = 5;

   localparam int DIV_STEPS = 32;
   localparam int DIV_LANES = 4;
   localparam int DIV_REM_W = 22;
   localparam logic [DIV_REM_W:0]   DIV_D    = 23'd3515625;
   localparam logic [DIV_REM_W-1:0] DIV_HALF = 22'd1757812;

   localparam int ROT_LANES = 5;
   localparam int VEC_W     = 35;

   localparam int SQRT_STEPS  = 31;
   localparam int SQRT_V_W    = 2 * SQRT_STEPS;
   localparam int SQRT_REM_W  = 33;
   localparam int SQRT_ROOT_W = 31;

   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
   localparam logic [31:0] CIRC_CM  = 32'd4003017359;
   localparam logic [30:0] DIST_MAX = 31'd2001508680;

   localparam logic signed [30:0] DEST_LAT_RESET = 31'sd129915189;
   localparam logic signed [31:0] DEST_LON_RESET = 32'sd802319912;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_LAT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_LON = 1'b1;

   localparam logic [31:0] ATAN_BAM [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   typedef struct packed {
      logic                 neg;
      logic [DIV_REM_W-1:0] rem;
      logic [31:0]          work;
   } div_lane_type;

   typedef struct packed {
      logic               flip;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } rot_lane_type;

   typedef struct packed {
      logic                    zero;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [31:0]             z;
   } vec_lane_type;

   typedef struct packed {
      logic [SQRT_V_W-1:0]    v;
      logic [SQRT_REM_W-1:0]  rem;
      logic [SQRT_ROOT_W-1:0] root;
   } sqrt_lane_type;

endpackage

### sv/gcbd_div_cell.sv
// One restoring step of the degree to binary-angle conversion divider.
// Uses gcbd_pkg for the divisor and the lane type.
module gcbd_div_cell (
   input  logic                                          clock,
   input  logic                                          en,
   input  gcbd_pkg::div_lane_type [gcbd_pkg::DIV_LANES-1:0] src,
   output gcbd_pkg::div_lane_type [gcbd_pkg::DIV_LANES-1:0] dst
);

   gcbd_pkg::div_lane_type [gcbd_pkg::DIV_LANES-1:0] dst_ff;
   gcbd_pkg::div_lane_type [gcbd_pkg::DIV_LANES-1:0] dst_in;

   always_comb begin
      logic [gcbd_pkg::DIV_REM_W:0] t;
      logic [gcbd_pkg::DIV_REM_W:0] d;
      for (int k = 0; k < gcbd_pkg::DIV_LANES; k++) begin
         t = {src[k].rem, src[k].work[31]};
         d = t - gcbd_pkg::DIV_D;
         dst_in[k].neg = src[k].neg;
         if (t >= gcbd_pkg::DIV_D) begin
            dst_in[k].rem  = d[gcbd_pkg::DIV_REM_W-1:0];
            dst_in[k].work = {src[k].work[30:0], 1'b1};
         end else begin
            dst_in[k].rem  = t[gcbd_pkg::DIV_REM_W-1:0];
            dst_in[k].work = {src[k].work[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

### sv/gcbd_rot_cell.sv
// One CORDIC rotation step for all sine/cosine lanes.
// Uses gcbd_pkg for the arctangent table and the lane type.
module gcbd_rot_cell (
   input  logic                                          clock,
   input  logic                                          en,
   input  logic [gcbd_pkg::STEP_W-1:0]                   step_idx,
   input  gcbd_pkg::rot_lane_type [gcbd_pkg::ROT_LANES-1:0] src,
   output gcbd_pkg::rot_lane_type [gcbd_pkg::ROT_LANES-1:0] dst
);

   gcbd_pkg::rot_lane_type [gcbd_pkg::ROT_LANES-1:0] dst_ff;
   gcbd_pkg::rot_lane_type [gcbd_pkg::ROT_LANES-1:0] dst_in;

   always_comb begin
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] ang;
      ang = $signed(gcbd_pkg::ATAN_BAM[step_idx]);
      for (int k = 0; k < gcbd_pkg::ROT_LANES; k++) begin
         dx = $signed(src[k].y) >>> step_idx;
         dy = $signed(src[k].x) >>> step_idx;
         dst_in[k].flip = src[k].flip;
         if (!src[k].z[31]) begin
            dst_in[k].x = src[k].x - dx;
            dst_in[k].y = src[k].y + dy;
            dst_in[k].z = src[k].z - ang;
         end else begin
            dst_in[k].x = src[k].x + dx;
            dst_in[k].y = src[k].y - dy;
            dst_in[k].z = src[k].z + ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

### sv/gcbd_vec_cell.sv
// One CORDIC vectoring step of an atan2 chain.
// Uses gcbd_pkg for the arctangent table and the lane type.
module gcbd_vec_cell (
   input  logic                        clock,
   input  logic                        en,
   input  logic [gcbd_pkg::STEP_W-1:0] step_idx,
   input  gcbd_pkg::vec_lane_type      src,
   output gcbd_pkg::vec_lane_type      dst
);

   gcbd_pkg::vec_lane_type dst_ff;
   gcbd_pkg::vec_lane_type dst_in;

   always_comb begin
      logic signed [gcbd_pkg::VEC_W-1:0] dx;
      logic signed [gcbd_pkg::VEC_W-1:0] dy;
      logic [31:0]                       ang;
      ang = gcbd_pkg::ATAN_BAM[step_idx];
      dx  = $signed(src.y) >>> step_idx;
      dy  = $signed(src.x) >>> step_idx;
      dst_in.zero = src.zero;
      if (!src.y[gcbd_pkg::VEC_W-1] && (src.y != '0)) begin
         dst_in.x = src.x + dx;
         dst_in.y = src.y - dy;
         dst_in.z = src.z + ang;
      end else begin
         dst_in.x = src.x - dx;
         dst_in.y = src.y + dy;
         dst_in.z = src.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

### sv/gcbd_sqrt_cell.sv
// One root bit of the restoring integer square root.
// Uses gcbd_pkg for the lane type and widths.
module gcbd_sqrt_cell (
   input  logic                    clock,
   input  logic                    en,
   input  gcbd_pkg::sqrt_lane_type src,
   output gcbd_pkg::sqrt_lane_type dst
);

   gcbd_pkg::sqrt_lane_type dst_ff;
   gcbd_pkg::sqrt_lane_type dst_in;

   always_comb begin
      logic [gcbd_pkg::SQRT_REM_W+1:0] r2;
      logic [gcbd_pkg::SQRT_REM_W+1:0] trial;
      logic [gcbd_pkg::SQRT_REM_W+1:0] diff;
      r2    = {src.rem, src.v[gcbd_pkg::SQRT_V_W-1 -: 2]};
      trial = {2'b00, src.root, 2'b01};
      diff  = r2 - trial;
      dst_in.v = {src.v[gcbd_pkg::SQRT_V_W-3:0], 2'b00};
      if (r2 >= trial) begin
         dst_in.rem  = diff[gcbd_pkg::SQRT_REM_W-1:0];
         dst_in.root = {src.root[gcbd_pkg::SQRT_ROOT_W-2:0], 1'b1};
      end else begin
         dst_in.rem  = r2[gcbd_pkg::SQRT_REM_W-1:0];
         dst_in.root = {src.root[gcbd_pkg::SQRT_ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

### sv/great_circle_bearing_distance.sv
// Great-circle bearing and haversine distance from a position fix to a
// destination held in two registers (csr_index 0 latitude, 1 longitude,
// 1e-7 degree). A fully pipelined row of cells takes one fix per cycle.
// It holds a 32-step conversion divider, the sine/cosine rotation chain,
// the multiply stages, a 31-step square root and the two arctangent
// chains. A stalled output freezes the row; one skid beat keeps
// req_stall registered. Write the registers only while idle.
// Depends on gcbd_pkg, the four cell modules and the assertion header.
`include "great_circle_bearing_distance_defines.svh"

module great_circle_bearing_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [30:0]                  req_cur_latitude,
   input  logic signed [31:0]                  req_cur_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [15:0]                         rsp_bearing_angle,
   output logic [30:0]                         rsp_distance_cm,
   input  logic                                csr_write,
   input  logic [gcbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_wdata
);

   localparam int NIT       = gcbd_pkg::ANGLE_ITERATIONS;
   localparam int LAT       = gcbd_pkg::DIV_STEPS + gcbd_pkg::SQRT_STEPS + 2 * NIT + 10;
   localparam int BRG_DELAY = gcbd_pkg::SQRT_STEPS + 2;

   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[61:30];
   endfunction

   logic signed [30:0] dest_lat_ff;
   logic signed [31:0] dest_lon_ff;
   logic               skid_vld_ff;
   logic signed [30:0] skid_lat_ff;
   logic signed [31:0] skid_lon_ff;
   logic [LAT-1:0]     vld_ff;
   logic               adv;
   logic               src_vld;
   logic signed [30:0] src_lat;
   logic signed [31:0] src_lon;

   logic signed [31:0] raw_ff [gcbd_pkg::DIV_LANES];
   logic [31:0]        bam_ff [gcbd_pkg::DIV_LANES];
   logic [31:0]        p1_ff, p2_ff, dl_ff, dp_ff;
   logic signed [31:0] s_ff [gcbd_pkg::ROT_LANES];
   logic signed [31:0] c_ff [gcbd_pkg::ROT_LANES];
   logic signed [31:0] by1_ff, t1_ff, t2_ff, hs1_ff, hs2_ff, u_ff, cdl_ff;
   logic signed [31:0] by2_ff, t1b_ff, t3_ff, hs1b_ff, w_ff;
   logic signed [32:0] bx_ff;
   logic signed [31:0] by3_ff;
   logic [30:0]        a_ff;
   logic [63:0]        prod_ff;
   logic [30:0]        dist_ff;
   logic [15:0]        brg_ff [BRG_DELAY];

   gcbd_pkg::div_lane_type [gcbd_pkg::DIV_LANES-1:0] div_chain [gcbd_pkg::DIV_STEPS+1];
   gcbd_pkg::rot_lane_type [gcbd_pkg::ROT_LANES-1:0] rot_chain [NIT+1];
   gcbd_pkg::vec_lane_type  vb_chain [NIT+1];
   gcbd_pkg::vec_lane_type  vd_chain [NIT+1];
   gcbd_pkg::sqrt_lane_type sa_chain [gcbd_pkg::SQRT_STEPS+1];
   gcbd_pkg::sqrt_lane_type sb_chain [gcbd_pkg::SQRT_STEPS+1];
   gcbd_pkg::vec_lane_type  vb_src_ff;
   gcbd_pkg::sqrt_lane_type sa_src_ff, sb_src_ff;

   gcbd_pkg::vec_lane_type  vb_src_in;
   gcbd_pkg::sqrt_lane_type sa_src_in, sb_src_in;
   logic signed [32:0]      bx_in;
   logic [30:0]             a_in;
   logic [63:0]             prod_in;
   logic [30:0]             dist_in;
   logic [15:0]             brg_in;

   // Handshake and skid beat.
   assign adv       = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = skid_vld_ff;
   assign src_vld   = skid_vld_ff || req_valid;
   assign src_lat   = skid_vld_ff ? skid_lat_ff : req_cur_latitude;
   assign src_lon   = skid_vld_ff ? skid_lon_ff : req_cur_longitude;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_lat_ff <= gcbd_pkg::DEST_LAT_RESET;
         dest_lon_ff <= gcbd_pkg::DEST_LON_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gcbd_pkg::CSR_DEST_LAT: dest_lat_ff <= csr_wdata[30:0];
            gcbd_pkg::CSR_DEST_LON: dest_lon_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
         vld_ff      <= '0;
      end else begin
         if (adv) begin
            skid_vld_ff <= 1'b0;
            vld_ff      <= {vld_ff[LAT-2:0], src_vld};
         end else if (req_valid && !skid_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && req_valid && !skid_vld_ff) begin
         skid_lat_ff <= req_cur_latitude;
         skid_lon_ff <= req_cur_longitude;
      end
   end

   // Conversion divider input: magnitude with the rounding half appended.
   always_comb begin
      logic [31:0] mag;
      for (int k = 0; k < gcbd_pkg::DIV_LANES; k++) begin
         mag = raw_ff[k][31] ? 32'(32'd0 - raw_ff[k]) : raw_ff[k];
         div_chain[0][k].neg  = raw_ff[k][31];
         div_chain[0][k].rem  = mag[31:10];
         div_chain[0][k].work = {mag[9:0], gcbd_pkg::DIV_HALF};
      end
   end

   for (genvar i = 0; i < gcbd_pkg::DIV_STEPS; i++) begin : g_div
      gcbd_div_cell u_div (
         .clock (clock),
         .en    (adv),
         .src   (div_chain[i]),
         .dst   (div_chain[i+1])
      );
   end

   // Quadrant fold: adding a half turn only toggles the top bit.
   always_comb begin
      logic [31:0] ang [gcbd_pkg::ROT_LANES];
      logic        flip;
      ang[0] = p1_ff;
      ang[1] = p2_ff;
      ang[2] = dl_ff;
      ang[3] = {1'b0, dp_ff[31:1]};
      ang[4] = {1'b0, dl_ff[31:1]};
      for (int k = 0; k < gcbd_pkg::ROT_LANES; k++) begin
         flip = ang[k][31] ^ ang[k][30];
         rot_chain[0][k].flip = flip;
         rot_chain[0][k].x    = gcbd_pkg::CORDIC_GAIN;
         rot_chain[0][k].y    = '0;
         rot_chain[0][k].z    = $signed({ang[k][31] ^ flip, ang[k][30:0]});
      end
   end

   for (genvar i = 0; i < NIT; i++) begin : g_rot
      gcbd_rot_cell u_rot (
         .clock    (clock),
         .en       (adv),
         .step_idx (gcbd_pkg::STEP_W'(i)),
         .src      (rot_chain[i]),
         .dst      (rot_chain[i+1])
      );
   end

   always_comb begin
      logic signed [32:0] sum;
      logic signed [gcbd_pkg::VEC_W-1:0] xb;
      logic signed [gcbd_pkg::VEC_W-1:0] yb;
      bx_in = {t1b_ff[31], t1b_ff} - {t3_ff[31], t3_ff};
      sum   = {hs1b_ff[31], hs1b_ff} + {w_ff[31], w_ff};
      if (sum[32]) begin
         a_in = '0;
      end else if (sum > $signed({2'b00, gcbd_pkg::ONE_Q30})) begin
         a_in = gcbd_pkg::ONE_Q30;
      end else begin
         a_in = sum[30:0];
      end
      xb = {{2{bx_ff[32]}}, bx_ff};
      yb = {{3{by3_ff[31]}}, by3_ff};
      vb_src_in.zero = (bx_ff == '0) && (by3_ff == '0);
      if (bx_ff[32]) begin
         vb_src_in.x = -xb;
         vb_src_in.y = -yb;
         vb_src_in.z = 32'h8000_0000;
      end else begin
         vb_src_in.x = xb;
         vb_src_in.y = yb;
         vb_src_in.z = '0;
      end
      sa_src_in.v    = {1'b0, a_ff, 30'd0};
      sa_src_in.rem  = '0;
      sa_src_in.root = '0;
      sb_src_in.v    = {1'b0, 31'(gcbd_pkg::ONE_Q30 - a_ff), 30'd0};
      sb_src_in.rem  = '0;
      sb_src_in.root = '0;
   end

   assign vb_chain[0] = vb_src_ff;
   assign sa_chain[0] = sa_src_ff;
   assign sb_chain[0] = sb_src_ff;

   for (genvar i = 0; i < NIT; i++) begin : g_vb
      gcbd_vec_cell u_vec (
         .clock    (clock),
         .en       (adv),
         .step_idx (gcbd_pkg::STEP_W'(i)),
         .src      (vb_chain[i]),
         .dst      (vb_chain[i+1])
      );
   end

   for (genvar i = 0; i < gcbd_pkg::SQRT_STEPS; i++) begin : g_sq
      gcbd_sqrt_cell u_sqa (
         .clock (clock),
         .en    (adv),
         .src   (sa_chain[i]),
         .dst   (sa_chain[i+1])
      );
      gcbd_sqrt_cell u_sqb (
         .clock (clock),
         .en    (adv),
         .src   (sb_chain[i]),
         .dst   (sb_chain[i+1])
      );
   end

   always_comb begin
      vd_chain[0].zero = (sa_chain[gcbd_pkg::SQRT_STEPS].root == '0) &&
                         (sb_chain[gcbd_pkg::SQRT_STEPS].root == '0);
      vd_chain[0].x    = {4'd0, sb_chain[gcbd_pkg::SQRT_STEPS].root};
      vd_chain[0].y    = {4'd0, sa_chain[gcbd_pkg::SQRT_STEPS].root};
      vd_chain[0].z    = '0;
   end

   for (genvar i = 0; i < NIT; i++) begin : g_vd
      gcbd_vec_cell u_vec (
         .clock    (clock),
         .en       (adv),
         .step_idx (gcbd_pkg::STEP_W'(i)),
         .src      (vd_chain[i]),
         .dst      (vd_chain[i+1])
      );
   end

   always_comb begin
      logic [31:0] hv;
      logic [30:0] h;
      logic [63:0] rnd;
      logic [31:0] bz;
      logic [31:0] br;
      hv = vd_chain[NIT].zero ? 32'd0 : vd_chain[NIT].z;
      h  = (hv > {1'b0, gcbd_pkg::ONE_Q30}) ? gcbd_pkg::ONE_Q30 : hv[30:0];
      prod_in = {32'd0, h, 1'b0} * {32'd0, gcbd_pkg::CIRC_CM};
      rnd = prod_ff + 64'h0000_0000_8000_0000;
      if (rnd[63:32] > {1'b0, gcbd_pkg::DIST_MAX}) begin
         dist_in = gcbd_pkg::DIST_MAX;
      end else begin
         dist_in = rnd[62:32];
      end
      bz     = vb_chain[NIT].zero ? 32'd0 : vb_chain[NIT].z;
      br     = bz + 32'h0000_8000;
      brg_in = br[31:16];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         raw_ff[0] <= {src_lat[30], src_lat};
         raw_ff[1] <= src_lon;
         raw_ff[2] <= {dest_lat_ff[30], dest_lat_ff};
         raw_ff[3] <= dest_lon_ff;
         for (int k = 0; k < gcbd_pkg::DIV_LANES; k++) begin
            bam_ff[k] <= div_chain[gcbd_pkg::DIV_STEPS][k].neg ?
                         32'(32'd0 - div_chain[gcbd_pkg::DIV_STEPS][k].work) :
                         div_chain[gcbd_pkg::DIV_STEPS][k].work;
         end
         p1_ff <= bam_ff[0];
         p2_ff <= bam_ff[2];
         dl_ff <= bam_ff[3] - bam_ff[1];
         dp_ff <= bam_ff[2] - bam_ff[0];
         for (int k = 0; k < gcbd_pkg::ROT_LANES; k++) begin
            s_ff[k] <= rot_chain[NIT][k].flip ? -rot_chain[NIT][k].y : rot_chain[NIT][k].y;
            c_ff[k] <= rot_chain[NIT][k].flip ? -rot_chain[NIT][k].x : rot_chain[NIT][k].x;
         end
         by1_ff  <= mul_q30(s_ff[2], c_ff[1]);
         t1_ff   <= mul_q30(c_ff[0], s_ff[1]);
         t2_ff   <= mul_q30(s_ff[0], c_ff[1]);
         hs1_ff  <= mul_q30(s_ff[3], s_ff[3]);
         hs2_ff  <= mul_q30(s_ff[4], s_ff[4]);
         u_ff    <= mul_q30(c_ff[0], c_ff[1]);
         cdl_ff  <= c_ff[2];
         t3_ff   <= mul_q30(t2_ff, cdl_ff);
         w_ff    <= mul_q30(u_ff, hs2_ff);
         t1b_ff  <= t1_ff;
         by2_ff  <= by1_ff;
         hs1b_ff <= hs1_ff;
         bx_ff   <= bx_in;
         by3_ff  <= by2_ff;
         a_ff    <= a_in;
         vb_src_ff <= vb_src_in;
         sa_src_ff <= sa_src_in;
         sb_src_ff <= sb_src_in;
         prod_ff <= prod_in;
         dist_ff <= dist_in;
         brg_ff[0] <= brg_in;
         for (int k = 1; k < BRG_DELAY; k++) begin
            brg_ff[k] <= brg_ff[k-1];
         end
      end
   end

   assign rsp_bearing_angle = brg_ff[BRG_DELAY-1];
   assign rsp_distance_cm   = dist_ff;

   `GCBD_ASSERT_NEXT(a_row_frozen, clock, reset, !adv, $stable(vld_ff), "valid row moved while output blocked")
   `GCBD_ASSERT_SAME(a_skid_fill, clock, reset, $rose(skid_vld_ff), $past(!adv) && $past(req_valid), "skid beat taken without a blocked row")
   `GCBD_ASSERT_NEXT(a_skid_drain, clock, reset, skid_vld_ff && adv, !skid_vld_ff && vld_ff[0], "skid beat not moved into the row")
   `GCBD_ASSERT_SAME(a_dist_sat, clock, reset, rsp_valid, rsp_distance_cm <= gcbd_pkg::DIST_MAX, "distance above half circumference")

endmodule
